[hw/rtl/buq_pkg.sv]
// buq_pkg: shared types and codes of the buffered uart byte queues block
// holds the request/response word types, opcodes, fsm states and the
// controller-to-datapath command struct; depends on nothing
package buq_pkg;

   // opcodes of the request word
   localparam logic [2:0] OP_RX_BYTE = 3'd0;
   localparam logic [2:0] OP_TX_DONE = 3'd1;
   localparam logic [2:0] OP_SEND    = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_POLL    = 3'd4;

   // request word
   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data_byte;
   } req_type;

   // response word
   typedef struct packed {
      logic       tx_start;
      logic [7:0] tx_byte;
      logic       send_accepted;
      logic [7:0] read_data;
      logic [6:0] rx_level;
      logic       overflow_event;
   } rsp_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // capture the request word
      logic exec;     // apply the opcode to the queues
      logic respond;  // drive the response word
   } cmd_type;

endpackage

[hw/rtl/buq_ctrl.sv]
// buq_ctrl: controller state machine of the byte queues block
// sequences capture, execute and respond for one request word
// depends on buq_pkg
module buq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_valid,
   output buq_pkg::cmd_type cmd
);

   buq_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= buq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         buq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = buq_pkg::ST_EXEC;
            end
         end
         buq_pkg::ST_EXEC: begin
            state_in = buq_pkg::ST_RESP;
         end
         buq_pkg::ST_RESP: begin
            state_in = buq_pkg::ST_IDLE;
         end
         default: begin
            state_in = buq_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.exec    = 1'b0;
      cmd.respond = 1'b0;
      unique case (state_ff)
         buq_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         buq_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         buq_pkg::ST_RESP: begin
            rsp_valid   = 1'b1;
            cmd.respond = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // an accepted word keeps the block busy next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // a response always follows an execute cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.exec))
      else $error("response without execute");

   // one strobe per word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

endmodule

[hw/rtl/buq_dpath.sv]
// buq_dpath: datapath of the byte queues block
// receive ring fifo, transmit queue, pointers, counts and sticky flag
// depends on buq_pkg
module buq_dpath #(
   parameter int RX_DEPTH = 64,
   parameter int TX_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  buq_pkg::cmd_type cmd,
   input  buq_pkg::req_type req_data,
   output buq_pkg::rsp_type rsp_data
);

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);

   // request word register
   buq_pkg::req_type req_ff;

   // queue control state
   logic [RX_AW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [RX_CW-1:0] rx_fill_ff, rx_fill_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [TX_CW-1:0] tx_pending_ff, tx_pending_in;
   logic             ovf_flag_ff, ovf_flag_in;

   // memories and registered read data
   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];
   logic [7:0] rx_rd_ff, tx_rd_ff;

   // response flags from the execute cycle
   logic       start_ff, start_in;
   logic       from_mem_ff, from_mem_in;
   logic       acc_ff, acc_in;
   logic       rd_ff, rd_in;
   logic       ovf_ev_ff, ovf_ev_in;
   logic       rx_wr, tx_wr;

   logic [31:0] fill_ext;

   // capture request word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // opcode decode and next state
   always_comb begin
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      rx_fill_in    = rx_fill_ff;
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      tx_pending_in = tx_pending_ff;
      ovf_flag_in   = ovf_flag_ff;
      start_in      = 1'b0;
      from_mem_in   = 1'b0;
      acc_in        = 1'b0;
      rd_in         = 1'b0;
      ovf_ev_in     = 1'b0;
      rx_wr         = 1'b0;
      tx_wr         = 1'b0;
      unique case (req_ff.opcode)
         buq_pkg::OP_RX_BYTE: begin
            if (rx_fill_ff != RX_CW'(RX_DEPTH)) begin
               rx_wr      = 1'b1;
               rx_fill_in = rx_fill_ff + RX_CW'(1);
               rx_head_in = (rx_head_ff == RX_AW'(RX_DEPTH - 1)) ? '0
                          : rx_head_ff + RX_AW'(1);
            end else begin
               ovf_flag_in = 1'b1;
            end
         end
         buq_pkg::OP_TX_DONE: begin
            if (tx_pending_ff == TX_CW'(1)) begin
               tx_pending_in = '0;
            end else if (tx_pending_ff != '0) begin
               tx_pending_in = tx_pending_ff - TX_CW'(1);
               start_in      = 1'b1;
               from_mem_in   = 1'b1;
               tx_tail_in    = (tx_tail_ff == TX_AW'(TX_DEPTH - 1)) ? '0
                             : tx_tail_ff + TX_AW'(1);
            end
         end
         buq_pkg::OP_SEND: begin
            if (tx_pending_ff == '0) begin
               start_in      = 1'b1;
               tx_pending_in = TX_CW'(1);
               acc_in        = 1'b1;
            end else if (tx_pending_ff != TX_CW'(TX_DEPTH)) begin
               tx_wr         = 1'b1;
               tx_pending_in = tx_pending_ff + TX_CW'(1);
               tx_head_in    = (tx_head_ff == TX_AW'(TX_DEPTH - 1)) ? '0
                             : tx_head_ff + TX_AW'(1);
               acc_in        = 1'b1;
            end else begin
               ovf_flag_in = 1'b1;
            end
         end
         buq_pkg::OP_READ: begin
            if (rx_fill_ff != '0) begin
               rd_in      = 1'b1;
               rx_fill_in = rx_fill_ff - RX_CW'(1);
               rx_tail_in = (rx_tail_ff == RX_AW'(RX_DEPTH - 1)) ? '0
                          : rx_tail_ff + RX_AW'(1);
            end
         end
         buq_pkg::OP_POLL: begin
            ovf_ev_in   = ovf_flag_ff;
            ovf_flag_in = 1'b0;
         end
         default: begin
            ovf_ev_in = 1'b0;
         end
      endcase
   end

   // control registers, updated in the execute cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff    <= '0;
         rx_tail_ff    <= '0;
         rx_fill_ff    <= '0;
         tx_head_ff    <= '0;
         tx_tail_ff    <= '0;
         tx_pending_ff <= '0;
         ovf_flag_ff   <= 1'b0;
      end else if (cmd.exec) begin
         rx_head_ff    <= rx_head_in;
         rx_tail_ff    <= rx_tail_in;
         rx_fill_ff    <= rx_fill_in;
         tx_head_ff    <= tx_head_in;
         tx_tail_ff    <= tx_tail_in;
         tx_pending_ff <= tx_pending_in;
         ovf_flag_ff   <= ovf_flag_in;
      end
   end

   // response flags
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         start_ff    <= start_in;
         from_mem_ff <= from_mem_in;
         acc_ff      <= acc_in;
         rd_ff       <= rd_in;
         ovf_ev_ff   <= ovf_ev_in;
      end
   end

   // receive memory: write at head, read at tail
   always_ff @(posedge clock) begin
      if (cmd.exec && rx_wr) begin
         rx_mem[rx_head_ff] <= req_ff.data_byte;
      end
      if (cmd.exec) begin
         rx_rd_ff <= rx_mem[rx_tail_ff];
      end
   end

   // transmit memory: write at head, read at tail
   always_ff @(posedge clock) begin
      if (cmd.exec && tx_wr) begin
         tx_mem[tx_head_ff] <= req_ff.data_byte;
      end
      if (cmd.exec) begin
         tx_rd_ff <= tx_mem[tx_tail_ff];
      end
   end

   // response word, fill level already reflects the step
   assign fill_ext = 32'(rx_fill_ff);

   always_comb begin
      rsp_data = '0;
      if (cmd.respond) begin
         rsp_data.tx_start       = start_ff;
         rsp_data.tx_byte        = !start_ff ? 8'd0
                                 : (from_mem_ff ? tx_rd_ff : req_ff.data_byte);
         rsp_data.send_accepted  = acc_ff;
         rsp_data.read_data      = rd_ff ? rx_rd_ff : 8'd0;
         rsp_data.rx_level       = fill_ext[6:0];
         rsp_data.overflow_event = ovf_ev_ff;
      end
   end

   // receive fill never exceeds the depth
   assert property (@(posedge clock) disable iff (reset)
      rx_fill_ff <= RX_CW'(RX_DEPTH))
      else $error("receive fill beyond depth");

   // transmit count never exceeds the depth
   assert property (@(posedge clock) disable iff (reset)
      tx_pending_ff <= TX_CW'(TX_DEPTH))
      else $error("transmit count beyond depth");

   // queue state moves only in an execute cycle
   assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> ($stable(rx_fill_ff) && $stable(tx_pending_ff)))
      else $error("queue state changed outside execute");

endmodule

[hw/rtl/buffered_uart_byte_queues_unit.sv]
// buffered_uart_byte_queues_unit: uart receive fifo and transmit queue
// command-style front end; joins buq_ctrl and buq_dpath
// depends on buq_pkg, buq_ctrl, buq_dpath
//
// Usage:
//   A request word (opcode, data_byte) on req_data is taken at a rising edge
//   where start is high and busy is low. Opcodes: rx byte arrived, tx done,
//   send byte, read byte, poll overflow flag.
//   Exactly one response word follows on rsp_data, marked by rsp_valid for
//   one cycle, in the response state that follows the execute state. busy
//   stays high until the edge that ends the response cycle, so no new word
//   is taken before the last one has had its response. The execute state does
//   the pointer/count update and the memory accesses; the memory read is registered.
//   The receiver cannot stall: the response is shown for one cycle only.
//   Reset (synchronous, active high) empties both queues and clears the
//   overflow flag; memory contents are not cleared and need no sweep.
module buffered_uart_byte_queues_unit #(
   parameter int RX_DEPTH = 64,
   parameter int TX_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  buq_pkg::req_type req_data,
   output logic             rsp_valid,
   output buq_pkg::rsp_type rsp_data
);

   buq_pkg::cmd_type cmd;

   // controller
   buq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // datapath
   buq_dpath #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

[tb/buq_queue_checker.sv]
// buq_queue_checker: watches the request and response words of the uart byte queues unit,
// predicts every response from its own copy of the queues and compares field by field
// depends on buq_pkg
`timescale 1ns / 1ps
module buq_queue_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  buq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  buq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               words_in,
   output int               words_checked,
   output int               words_due
);

   localparam int RX_SLOTS = 64;
   localparam int TX_SLOTS = 64;
   localparam int SHOW_LIMIT = 10;

   // shadow of the receive fifo
   logic [7:0] rx_bytes [RX_SLOTS];
   logic [5:0] rx_wr;
   logic [5:0] rx_rd;
   logic [6:0] rx_held;

   // shadow of the transmit queue; tx_owed counts the byte in flight too
   logic [7:0] tx_bytes [TX_SLOTS];
   logic [5:0] tx_wr;
   logic [5:0] tx_rd;
   logic [6:0] tx_owed;
   logic       ovf_sticky;

   // responses predicted but not yet seen
   buq_pkg::rsp_type rsp_due_q [$];

   // apply one event to the shadow queues and build its response word
   function automatic buq_pkg::rsp_type apply_event(input buq_pkg::req_type w);
      buq_pkg::rsp_type r;
      r = '0;
      case (w.opcode)
         buq_pkg::OP_RX_BYTE: begin
            if (rx_held < RX_SLOTS) begin
               rx_bytes[rx_wr] = w.data_byte;
               rx_held = rx_held + 7'd1;
               rx_wr = rx_wr + 6'd1;  // 64 entries: index wraps by itself
            end else begin
               ovf_sticky = 1'b1;
            end
         end
         buq_pkg::OP_TX_DONE: begin
            if (tx_owed == 7'd1) begin
               tx_owed = 7'd0;
            end else if (tx_owed > 7'd1) begin
               // retire the byte in flight, launch the oldest queued one
               tx_owed = tx_owed - 7'd1;
               r.tx_start = 1'b1;
               r.tx_byte = tx_bytes[tx_rd];
               tx_rd = tx_rd + 6'd1;
            end
         end
         buq_pkg::OP_SEND: begin
            if (tx_owed == 7'd0) begin
               // transmitter idle: byte goes straight out
               r.tx_start = 1'b1;
               r.tx_byte = w.data_byte;
               r.send_accepted = 1'b1;
               tx_owed = 7'd1;
            end else if (tx_owed < TX_SLOTS) begin
               tx_bytes[tx_wr] = w.data_byte;
               tx_owed = tx_owed + 7'd1;
               tx_wr = tx_wr + 6'd1;
               r.send_accepted = 1'b1;
            end else begin
               ovf_sticky = 1'b1;
            end
         end
         buq_pkg::OP_READ: begin
            if (rx_held > 7'd0) begin
               r.read_data = rx_bytes[rx_rd];
               rx_held = rx_held - 7'd1;
               rx_rd = rx_rd + 6'd1;
            end
         end
         buq_pkg::OP_POLL: begin
            r.overflow_event = ovf_sticky;
            ovf_sticky = 1'b0;
         end
         default: begin
         end
      endcase
      r.rx_level = rx_held;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input buq_pkg::rsp_type want,
                                  input buq_pkg::rsp_type got);
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
         $display("mismatch (%s) at %0t: want start=%0d byte=%02h acc=%0d rd=%02h lvl=%0d ovf=%0d",
                  what, $realtime, want.tx_start, want.tx_byte, want.send_accepted,
                  want.read_data, want.rx_level, want.overflow_event);
      if (fail_count <= SHOW_LIMIT)
         $display("   got start=%0d byte=%02h acc=%0d rd=%02h lvl=%0d ovf=%0d",
                  got.tx_start, got.tx_byte, got.send_accepted, got.read_data,
                  got.rx_level, got.overflow_event);
   endtask

   // sample both channels at each rising edge
   always @(posedge clock) begin
      buq_pkg::rsp_type want;
      if (reset) begin
         rx_wr = '0;
         rx_rd = '0;
         rx_held = '0;
         tx_wr = '0;
         tx_rd = '0;
         tx_owed = '0;
         ovf_sticky = 1'b0;
         rsp_due_q.delete();
         fail_count = 0;
         words_in = 0;
         words_checked = 0;
      end else begin
         // response word leaving the block
         if (rsp_valid) begin
            words_checked++;
            if (rsp_due_q.size() == 0) begin
               report_mismatch("no word due", '0, rsp_data);
            end else begin
               want = rsp_due_q.pop_front();
               if (rsp_data.tx_start !== want.tx_start ||
                   rsp_data.tx_byte !== want.tx_byte ||
                   rsp_data.send_accepted !== want.send_accepted ||
                   rsp_data.read_data !== want.read_data ||
                   rsp_data.rx_level !== want.rx_level ||
                   rsp_data.overflow_event !== want.overflow_event)
                  report_mismatch("field", want, rsp_data);
            end
         end
         // request word taken by the block
         if (start && !busy) begin
            rsp_due_q.push_back(apply_event(req_data));
            words_in++;
         end
      end
      words_due = rsp_due_q.size();
   end

endmodule

[tb/buffered_uart_byte_queues_unit_test.sv]
// buffered_uart_byte_queues_unit_test: drives directed and random request words into the
// uart byte queues unit with random gaps and reports the verdict
// depends on buq_pkg, buffered_uart_byte_queues_unit, buq_queue_checker
`timescale 1ns / 1ps
module buffered_uart_byte_queues_unit_test;

   localparam int RANDOM_WORDS = 550;
   localparam int CALM_TAIL = 100;  // last words sent back to back
   localparam int PHASE_LEN = 90;

   typedef enum logic [2:0] {
      MIX_ANY,
      RX_FILL,
      RX_DRAIN,
      TX_FILL,
      TX_DRAIN
   } mix_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   buq_pkg::req_type req_data = '0;
   logic             busy;
   logic             rsp_valid;
   buq_pkg::rsp_type rsp_data;

   int fail_count;
   int words_in;
   int words_checked;
   int words_due;
   int gaps_on;
   mix_type mix;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   buffered_uart_byte_queues_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   buq_queue_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .words_in      (words_in),
      .words_checked (words_checked),
      .words_due     (words_due)
   );

   // present one word, optionally after a gap, and return at the edge that takes it
   task automatic drive_word(input logic [2:0] op, input logic [7:0] b);
      int gap;
      gap = 0;
      if (gaps_on != 0 && $urandom_range(0, 2) == 0)
         gap = $urandom_range(1, 9);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= {op, b};
      do @(posedge clock); while (busy);
   endtask

   // opcode mix per phase: fill phases push a queue past full, drain phases lower its level
   function automatic logic [2:0] pick_op(input mix_type m);
      int roll;
      logic [2:0] op;
      roll = $urandom_range(0, 99);
      case (m)
         RX_FILL:  op = roll < 85 ? buq_pkg::OP_RX_BYTE
                                  : (roll < 92 ? buq_pkg::OP_READ : buq_pkg::OP_POLL);
         RX_DRAIN: op = roll < 70 ? buq_pkg::OP_READ
                                  : (roll < 88 ? buq_pkg::OP_RX_BYTE : buq_pkg::OP_POLL);
         TX_FILL:  op = roll < 85 ? buq_pkg::OP_SEND
                                  : (roll < 92 ? buq_pkg::OP_TX_DONE : buq_pkg::OP_POLL);
         TX_DRAIN: op = roll < 70 ? buq_pkg::OP_TX_DONE
                                  : (roll < 88 ? buq_pkg::OP_SEND : buq_pkg::OP_POLL);
         default: begin
            if (roll < 92)
               op = 3'($urandom_range(buq_pkg::OP_RX_BYTE, buq_pkg::OP_POLL));
            else
               op = 3'($urandom_range(buq_pkg::OP_POLL + 1, 7));
         end
      endcase
      return op;
   endfunction

   initial begin
      gaps_on = 1;
      mix = MIX_ANY;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, empty read, tx done while idle and with one pending
      drive_word(buq_pkg::OP_RX_BYTE, 8'h00);
      drive_word(buq_pkg::OP_RX_BYTE, 8'hFF);
      drive_word(buq_pkg::OP_RX_BYTE, 8'hA5);
      drive_word(buq_pkg::OP_READ, 8'hFF);
      drive_word(buq_pkg::OP_READ, 8'h00);
      drive_word(buq_pkg::OP_READ, 8'h00);
      drive_word(buq_pkg::OP_READ, 8'h00);
      drive_word(buq_pkg::OP_TX_DONE, 8'hFF);
      drive_word(buq_pkg::OP_SEND, 8'hFF);
      drive_word(buq_pkg::OP_TX_DONE, 8'h00);
      drive_word(buq_pkg::OP_SEND, 8'h00);
      drive_word(buq_pkg::OP_SEND, 8'h5A);
      drive_word(buq_pkg::OP_SEND, 8'hC3);
      drive_word(buq_pkg::OP_TX_DONE, 8'h00);
      drive_word(buq_pkg::OP_TX_DONE, 8'h00);
      drive_word(buq_pkg::OP_TX_DONE, 8'h00);
      drive_word(buq_pkg::OP_POLL, 8'hFF);
      // spare opcodes change nothing
      for (int c = buq_pkg::OP_POLL + 1; c < 8; c++)
         drive_word(3'(c), 8'hFF);
      drive_word(buq_pkg::OP_POLL, 8'h00);

      // random: phased fill/drain of each queue, then shuffled mixes
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n < PHASE_LEN)
            mix = RX_FILL;
         else if (n < 2 * PHASE_LEN)
            mix = RX_DRAIN;
         else if (n < 3 * PHASE_LEN)
            mix = TX_FILL;
         else if (n < 4 * PHASE_LEN)
            mix = TX_DRAIN;
         else if (n % 25 == 0)
            mix = mix_type'($urandom_range(MIX_ANY, TX_DRAIN));
         if (n >= RANDOM_WORDS - CALM_TAIL)
            gaps_on = 0;
         else if (n % 30 == 0)
            gaps_on = $urandom_range(0, 3) != 0;
         drive_word(pick_op(mix), 8'($urandom_range(0, 255)));
      end
      start <= 1'b0;

      // drain outstanding responses, then keep watching for stray responses
      do @(negedge clock); while (words_due != 0);
      repeat (8) @(posedge clock);

      $display("summary: %0d request words, %0d response words checked, %0d mismatches",
               words_in, words_checked, fail_count);
      $display("summary: both queues driven past full and drained, spare opcodes, random gaps");
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
hw/rtl/buq_pkg.sv
hw/rtl/buq_ctrl.sv
hw/rtl/buq_dpath.sv
hw/rtl/buffered_uart_byte_queues_unit.sv
tb/buq_queue_checker.sv
tb/buffered_uart_byte_queues_unit_test.sv
